/* sv/range_gated_polar_to_cartesian_defines.svh */
// ----------------------------------------------------------------------------
// Range-gated polar to Cartesian: assertion macros
// Shared property wrappers for the checker; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_GATED_POLAR_TO_CARTESIAN_DEFINES_SVH
`define RANGE_GATED_POLAR_TO_CARTESIAN_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define RGPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define RGPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rgpc_pkg.sv */
// ----------------------------------------------------------------------------
// rgpc_pkg
// Widths, register codes, queue item type and the quarter-wave cosine table.
// ----------------------------------------------------------------------------
package rgpc_pkg;

    localparam int MAX_POINTS  = 4096;
    localparam int PHASE_BITS  = 12;
    localparam int ANGLE_BITS  = 12;
    localparam int QUARTER     = 1024;

    localparam int RANGE_BITS  = 16;
    localparam int INDEX_BITS  = 12;
    localparam int SPAN_BITS   = 13;
    localparam int CFG_BITS    = 16;
    localparam int COORD_BITS  = 17;
    localparam int TRIG_BITS   = 16;
    localparam int DIV_BITS    = $clog2(MAX_POINTS) + 1;
    localparam int REM_BITS    = DIV_BITS - 1;
    localparam int PROD_BITS   = INDEX_BITS + SPAN_BITS;
    localparam int ROM_ABITS   = $clog2(QUARTER) + 1;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        REG_THRESHOLD   = 2'd0,
        REG_MAX_ANGLE   = 2'd1,
        REG_SCAN_POINTS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [RANGE_BITS-1:0] range_mm;
        logic [INDEX_BITS-1:0] beam_index;
        logic [PROD_BITS-1:0]  dividend;
        logic [DIV_BITS-1:0]   divisor;
    } item_t;

    typedef logic [TRIG_BITS-1:0] cos_rom_t [0:QUARTER];

    // (a * b) >> 62 for Q62 operands
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // round(32767 * cos(2*pi*k/4096)) by series expansion in Q62
    function automatic logic [TRIG_BITS-1:0] cos_entry(input logic [63:0] k);
        logic [63:0] theta;
        logic [63:0] theta2;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] c;
        logic [63:0] v;
        theta  = k * (64'hC90FDAA22168C235 >> 11);
        theta2 = mul_q62(theta, theta);
        pos    = 64'd1 << 62;
        neg    = 64'd0;
        term   = 64'd1 << 62;
        for (int j = 1; j <= 16; j++) begin
            term = mul_q62(term, theta2) / 64'((2 * j - 1) * (2 * j));
            if (j % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        c = (neg > pos) ? 64'd0 : pos - neg;
        v = (c >> 16) * 64'd32767;
        v = (v + (64'd1 << 45)) >> 46;
        return v[TRIG_BITS-1:0];
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        for (int k = 0; k <= QUARTER; k++)
            rom[k] = cos_entry(64'(k));
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

/* sv/rgpc_front.sv */
// ----------------------------------------------------------------------------
// rgpc_front
// Holds the configuration, gates samples on range and forms the angle
// dividend and clamped divisor for each sample that yields a point.
// ----------------------------------------------------------------------------
module rgpc_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [rgpc_pkg::CFG_BITS-1:0]    cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [rgpc_pkg::RANGE_BITS-1:0]  range_mm,
    input  logic [rgpc_pkg::INDEX_BITS-1:0]  beam_index,
    output logic                             push_valid,
    output rgpc_pkg::item_t                  push_item,
    input  logic                             push_ready
);
    import rgpc_pkg::*;

    logic [RANGE_BITS-1:0] threshold_reg;
    logic [SPAN_BITS-1:0]  max_angle_reg;
    logic [SPAN_BITS-1:0]  scan_points_reg;
    logic [DIV_BITS-1:0]   divisor;
    logic                  gated;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= '1;
            max_angle_reg   <= SPAN_BITS'(4096);
            scan_points_reg <= SPAN_BITS'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD:   threshold_reg   <= cfg_data[RANGE_BITS-1:0];
                REG_MAX_ANGLE:   max_angle_reg   <= cfg_data[SPAN_BITS-1:0];
                REG_SCAN_POINTS: scan_points_reg <= cfg_data[SPAN_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp divisor to 1..MAX_POINTS
    always_comb
    begin
        if (scan_points_reg == '0)
            divisor = DIV_BITS'(1);
        else if ({{(32-SPAN_BITS){1'b0}}, scan_points_reg} > 32'(MAX_POINTS))
            divisor = DIV_BITS'(MAX_POINTS);
        else
            divisor = DIV_BITS'(scan_points_reg);
    end

    // Drop samples beyond the threshold; pass the rest on
    assign gated      = range_mm > threshold_reg;
    assign in_ready   = push_ready;
    assign push_valid = in_valid && !gated;

    always_comb
    begin
        push_item.range_mm   = range_mm;
        push_item.beam_index = beam_index;
        push_item.dividend   = PROD_BITS'(beam_index) * PROD_BITS'(max_angle_reg);
        push_item.divisor    = divisor;
    end

endmodule

/* sv/rgpc_queue.sv */
// ----------------------------------------------------------------------------
// rgpc_queue
// Short FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module rgpc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  rgpc_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rgpc_pkg::item_t pop_item
);
    import rgpc_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    item_t                 mem [0:QUEUE_DEPTH-1];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS:0]     count_reg;
    logic [PTR_BITS:0]     count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = count_reg != (PTR_BITS+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store incoming transfer
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

/* sv/rgpc_back.sv */
// ----------------------------------------------------------------------------
// rgpc_back
// Pipelined restoring divider for the beam phase, cosine table lookup,
// range scaling and rounding to the output register.
// ----------------------------------------------------------------------------
module rgpc_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pop_valid,
    output logic                                  pop_ready,
    input  rgpc_pkg::item_t                       pop_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [rgpc_pkg::COORD_BITS-1:0] point_x,
    output logic signed [rgpc_pkg::COORD_BITS-1:0] point_y,
    output logic [rgpc_pkg::INDEX_BITS-1:0]        point_index
);
    import rgpc_pkg::*;

    localparam int NS = PROD_BITS;

    logic adv;

    // Division stages: stage 0 holds the popped item, stage NS the quotient
    logic                  dv_valid_reg [0:NS];
    logic [PROD_BITS-1:0]  dv_num_reg   [0:NS];
    logic [REM_BITS-1:0]   dv_rem_reg   [0:NS];
    logic [PHASE_BITS-1:0] dv_quot_reg  [0:NS];
    logic [DIV_BITS-1:0]   dv_div_reg   [0:NS];
    logic [RANGE_BITS-1:0] dv_range_reg [0:NS];
    logic [INDEX_BITS-1:0] dv_index_reg [0:NS];

    // Table stage
    logic                  tb_valid_reg;
    logic [TRIG_BITS-1:0]  tb_cos_reg;
    logic [TRIG_BITS-1:0]  tb_sin_reg;
    logic                  tb_cos_neg_reg;
    logic                  tb_sin_neg_reg;
    logic [RANGE_BITS-1:0] tb_range_reg;
    logic [INDEX_BITS-1:0] tb_index_reg;

    // Multiply stage
    logic                  mu_valid_reg;
    logic [31:0]           mu_x_reg;
    logic [31:0]           mu_y_reg;
    logic                  mu_x_neg_reg;
    logic                  mu_y_neg_reg;
    logic [INDEX_BITS-1:0] mu_index_reg;

    // Output stage
    logic                          out_valid_reg;
    logic signed [COORD_BITS-1:0]  x_reg;
    logic signed [COORD_BITS-1:0]  y_reg;
    logic [INDEX_BITS-1:0]         index_reg;

    logic [ANGLE_BITS-1:0] cos_phase;
    logic [ANGLE_BITS-1:0] sin_phase;
    logic [ROM_ABITS-1:0]  cos_addr;
    logic [ROM_ABITS-1:0]  sin_addr;
    logic [COORD_BITS-1:0] x_mag;
    logic [COORD_BITS-1:0] y_mag;

    // Whole back end moves while the output register is free or being taken
    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;

    // Load stage 0 from the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_num_reg[0]   <= pop_item.dividend;
            dv_rem_reg[0]   <= '0;
            dv_quot_reg[0]  <= '0;
            dv_div_reg[0]   <= pop_item.divisor;
            dv_range_reg[0] <= pop_item.range_mm;
            dv_index_reg[0] <= pop_item.beam_index;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < NS; k++)
    begin : g_div
        logic [REM_BITS:0] trial;
        logic              fits;

        assign trial = {dv_rem_reg[k], dv_num_reg[k][NS-1-k]};
        assign fits  = trial >= dv_div_reg[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_num_reg[k+1]   <= dv_num_reg[k];
                dv_rem_reg[k+1]   <= fits ? REM_BITS'(trial - dv_div_reg[k])
                                          : REM_BITS'(trial);
                dv_quot_reg[k+1]  <= {dv_quot_reg[k][PHASE_BITS-2:0], fits};
                dv_div_reg[k+1]   <= dv_div_reg[k];
                dv_range_reg[k+1] <= dv_range_reg[k];
                dv_index_reg[k+1] <= dv_index_reg[k];
            end
        end
    end

    // Fold phase into a quarter-wave address; sine is cosine a quarter back
    assign cos_phase = ANGLE_BITS'(dv_quot_reg[NS]);
    assign sin_phase = cos_phase - ANGLE_BITS'(QUARTER);
    assign cos_addr  = cos_phase[ANGLE_BITS-2]
                     ? ROM_ABITS'(QUARTER) - ROM_ABITS'(cos_phase[ANGLE_BITS-3:0])
                     : ROM_ABITS'(cos_phase[ANGLE_BITS-3:0]);
    assign sin_addr  = sin_phase[ANGLE_BITS-2]
                     ? ROM_ABITS'(QUARTER) - ROM_ABITS'(sin_phase[ANGLE_BITS-3:0])
                     : ROM_ABITS'(sin_phase[ANGLE_BITS-3:0]);

    // Read the cosine table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tb_valid_reg <= 1'b0;
        else if (adv)
            tb_valid_reg <= dv_valid_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tb_cos_reg     <= COS_ROM[cos_addr];
            tb_sin_reg     <= COS_ROM[sin_addr];
            tb_cos_neg_reg <= cos_phase[ANGLE_BITS-1] ^ cos_phase[ANGLE_BITS-2];
            tb_sin_neg_reg <= sin_phase[ANGLE_BITS-1] ^ sin_phase[ANGLE_BITS-2];
            tb_range_reg   <= dv_range_reg[NS];
            tb_index_reg   <= dv_index_reg[NS];
        end
    end

    // Scale magnitudes by the range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mu_valid_reg <= 1'b0;
        else if (adv)
            mu_valid_reg <= tb_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mu_x_reg     <= 32'(tb_range_reg) * 32'(tb_cos_reg);
            mu_y_reg     <= 32'(tb_range_reg) * 32'(tb_sin_reg);
            mu_x_neg_reg <= tb_cos_neg_reg;
            mu_y_neg_reg <= tb_sin_neg_reg;
            mu_index_reg <= tb_index_reg;
        end
    end

    // Round half away from zero, then apply sign
    assign x_mag = COORD_BITS'((33'(mu_x_reg) + 33'd16384) >> 15);
    assign y_mag = COORD_BITS'((33'(mu_y_reg) + 33'd16384) >> 15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= mu_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg     <= mu_x_neg_reg ? -$signed(x_mag) : $signed(x_mag);
            y_reg     <= mu_y_neg_reg ? -$signed(y_mag) : $signed(y_mag);
            index_reg <= mu_index_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_x     = x_reg;
    assign point_y     = y_reg;
    assign point_index = index_reg;

endmodule

/* sv/range_gated_polar_to_cartesian.sv */
// ----------------------------------------------------------------------------
// range_gated_polar_to_cartesian
// Converts laser range samples with beam index into x/y points, dropping
// samples whose range exceeds a programmable threshold.
//
// Input channel: in_valid/in_ready with range_mm and beam_index. Output
// channel: out_valid/out_ready with point_x, point_y and point_index.
// Configuration: cfg_we with cfg_index (0 threshold, 1 max angle, 2 scan
// points) and cfg_data; write only while the block is idle.
// Throughput: one sample per cycle while the receiver keeps taking points.
// An accepted sample reaches out_valid through the 25-stage divider (one
// quotient bit per stage), the table read, the multiply and the rounding
// register. A gated sample is accepted and produces no transfer.
// Reset clears the pipeline and queue and restores the threshold to 65535,
// max angle to 4096 and scan points to 1024.
// When the receiver stalls, the back end holds; the four-entry queue keeps
// taking samples until full, then in_ready drops.
// ----------------------------------------------------------------------------
module range_gated_polar_to_cartesian (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [1:0]                             cfg_index,
    input  logic [rgpc_pkg::CFG_BITS-1:0]          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [rgpc_pkg::RANGE_BITS-1:0]        range_mm,
    input  logic [rgpc_pkg::INDEX_BITS-1:0]        beam_index,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [rgpc_pkg::COORD_BITS-1:0] point_x,
    output logic signed [rgpc_pkg::COORD_BITS-1:0] point_y,
    output logic [rgpc_pkg::INDEX_BITS-1:0]        point_index
);
    import rgpc_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    rgpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .range_mm   (range_mm),
        .beam_index (beam_index),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    rgpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    rgpc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_item    (pop_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_index (point_index)
    );

endmodule

/* sv/rgpc_checker.sv */
// ----------------------------------------------------------------------------
// rgpc_checker
// Port-level checks on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "range_gated_polar_to_cartesian_defines.svh"

module rgpc_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [rgpc_pkg::COORD_BITS-1:0] point_x,
    input logic signed [rgpc_pkg::COORD_BITS-1:0] point_y,
    input logic [rgpc_pkg::INDEX_BITS-1:0]        point_index
);
    import rgpc_pkg::*;

    localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Hold a stalled transfer
    `RGPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")
    `RGPC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(point_x) && $stable(point_y) && $stable(point_index), "payload changed while stalled")

    // Magnitudes never exceed the largest range
    `RGPC_ASSERT_NOW(a_x_range, out_valid, point_x != COORD_MIN, "point_x outside range")
    `RGPC_ASSERT_NOW(a_y_range, out_valid, point_y != COORD_MIN, "point_y outside range")

endmodule

bind range_gated_polar_to_cartesian rgpc_checker u_rgpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_index (point_index)
);

/* tb/range_gated_polar_to_cartesian_tb.sv */
// ----------------------------------------------------------------------------
// range_gated_polar_to_cartesian_tb
// Self-checking bench for the range-gated polar to Cartesian converter.
// A point predictor works out each expected x/y/index as samples are
// accepted. Gated samples predict nothing. Output transfers are checked in
// order against the oldest prediction. Register settings change between
// phases while the block is idle. Both channels idle at random, and the
// receiver holds off for one long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module range_gated_polar_to_cartesian_tb;

    import rgpc_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD = 300;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [INDEX_BITS-1:0] idx;
    } point_t;

    // Predict converted points and check them in arrival order
    class point_scoreboard;
        int cos_tab [0:QUARTER];
        point_t points_due [$];
        logic [15:0] threshold;
        logic [12:0] span;
        logic [12:0] beams;
        int errors;

        function new();
            for (int k = 0; k <= QUARTER; k++)
                cos_tab[k] = int'(32767.0 * $cos(2.0 * 3.14159265358979323846 * k / 4096.0));
            threshold = 16'd65535;
            span = 13'd4096;
            beams = 13'd1024;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_t which, logic [CFG_BITS-1:0] value);
            case (which)
                REG_THRESHOLD:   threshold = value;
                REG_MAX_ANGLE:   span = value[12:0];
                REG_SCAN_POINTS: beams = value[12:0];
                default: ;
            endcase
        endfunction

        function int signed_cos(logic [11:0] p);
            logic [9:0] r;
            r = p[9:0];
            case (p[11:10])
                2'd0: return cos_tab[r];
                2'd1: return -cos_tab[QUARTER - r];
                2'd2: return -cos_tab[r];
                default: return cos_tab[QUARTER - r];
            endcase
        endfunction

        function logic [COORD_BITS-1:0] scale_coord(logic [15:0] rng, int c);
            logic [33:0] mag;
            logic [33:0] r;
            mag = rng * 34'(c < 0 ? -c : c);
            r = (mag + 34'd16384) >> 15;
            return (c < 0) ? -r[COORD_BITS-1:0] : r[COORD_BITS-1:0];
        endfunction

        function void note_sample(logic [15:0] rng, logic [INDEX_BITS-1:0] idx);
            logic [24:0] prod;
            logic [12:0] divisor;
            logic [11:0] phase;
            point_t pt;
            if (rng > threshold)
                return;
            divisor = (beams == 0) ? 13'd1 : ((beams > MAX_POINTS) ? 13'(MAX_POINTS) : beams);
            prod = idx * span;
            phase = 12'((prod / divisor) % (1 << PHASE_BITS));
            pt.x = scale_coord(rng, signed_cos(phase));
            pt.y = scale_coord(rng, signed_cos(phase - 12'(QUARTER)));
            pt.idx = idx;
            points_due = {points_due, pt};
        endfunction

        function void check_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                  logic [INDEX_BITS-1:0] idx);
            point_t pt;
            if (points_due.size() == 0)
            begin
                $display("%0t: unexpected point x=%0d y=%0d index=%0d", $time,
                         $signed(x), $signed(y), idx);
                errors++;
                return;
            end
            pt = points_due.pop_front();
            if (x !== pt.x)
            begin
                $display("%0t: point_x expected %0d actual %0d", $time, $signed(pt.x), $signed(x));
                errors++;
            end
            if (y !== pt.y)
            begin
                $display("%0t: point_y expected %0d actual %0d", $time, $signed(pt.y), $signed(y));
                errors++;
            end
            if (idx !== pt.idx)
            begin
                $display("%0t: point_index expected %0d actual %0d", $time, pt.idx, idx);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [RANGE_BITS-1:0] range_mm = '0;
    logic [INDEX_BITS-1:0] beam_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic [INDEX_BITS-1:0] point_index;

    point_scoreboard board = new();
    int rx_mode = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int rx_tick = 0;
    int quiet_cycles = 0;

    range_gated_polar_to_cartesian dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .range_mm(range_mm), .beam_index(beam_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .point_x(point_x), .point_y(point_y), .point_index(point_index)
    );

    always #HALF_PERIOD clk = ~clk;

    // Offer one sample and hold it until the transfer
    task automatic send_sample(logic [15:0] rng, logic [INDEX_BITS-1:0] idx);
        @(negedge clk);
        in_valid <= 1'b1;
        range_mm <= rng;
        beam_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_sample(rng, idx);
    endtask

    // Drop valid for a gap of the given length
    task automatic sender_gap(int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] which, logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (which <= REG_SCAN_POINTS)
            board.set_reg(cfg_reg_t'(which), value);
    endtask

    // Wait until every point has arrived and the pipeline has emptied
    task automatic drain();
        sender_gap(1);
        while (board.points_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Send random samples in bursts, mostly within the threshold
    task automatic random_burst(int count);
        int burst;
        logic [15:0] rng;
        burst = $urandom_range(12, 1);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9, 0) < 8)
                rng = 16'($urandom_range(int'(board.threshold), 0));
            else
                rng = 16'($urandom);
            send_sample(rng, 12'($urandom));
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(12, 1);
                if ($urandom_range(3, 0) != 0)
                    sender_gap($urandom_range(6, 1));
            end
        end
    endtask

    // Drive out_ready: long hold on request, else the current stall pattern
    always @(negedge clk)
    begin
        rx_tick++;
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req = 0;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(1, 0) == 1);
                default: out_ready <= (rx_tick % 7) > 2;
            endcase
        end
    end

    // Check each output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_point(point_x, point_y, point_index);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes and every quadrant under reset settings
        send_sample(16'd0, 12'd0);
        send_sample(16'd65535, 12'd0);
        send_sample(16'd65535, 12'd4095);
        send_sample(16'd65535, 12'd256);
        send_sample(16'd65535, 12'd512);
        send_sample(16'd65535, 12'd768);
        send_sample(16'd12345, 12'd128);
        send_sample(16'd1, 12'd640);
        send_sample(16'd32768, 12'd900);
        drain();

        // Directed: gated samples around a threshold, zero divisor, dead span
        write_reg(REG_THRESHOLD, 16'd1000);
        write_reg(REG_SCAN_POINTS, 16'd0);
        write_reg(REG_MAX_ANGLE, 16'd0);
        send_sample(16'd1000, 12'd7);
        send_sample(16'd1001, 12'd8);
        send_sample(16'd65535, 12'd9);
        send_sample(16'd0, 12'd4095);
        drain();
        write_reg(REG_MAX_ANGLE, 16'd1);
        send_sample(16'd999, 12'd1024);
        send_sample(16'd1000, 12'd4095);
        drain();

        // Directed: oversized divisor, wide span, ignored extra register index
        write_reg(REG_THRESHOLD, 16'd65535);
        write_reg(REG_SCAN_POINTS, 16'hFFFF);
        write_reg(REG_MAX_ANGLE, 16'hFFFF);
        write_reg(2'd3, 16'd5);
        send_sample(16'd50000, 12'd4095);
        send_sample(16'd50000, 12'd2048);
        send_sample(16'd40000, 12'd1);
        drain();

        // Random phases across several settings
        rx_mode = 1;
        random_burst(120);
        drain();
        write_reg(REG_MAX_ANGLE, 16'd4096);
        write_reg(REG_SCAN_POINTS, 16'd1);
        rx_mode = 2;
        random_burst(120);
        drain();
        write_reg(REG_SCAN_POINTS, 16'd4096);
        write_reg(REG_THRESHOLD, 16'd40000);
        rx_mode = 0;
        random_burst(120);
        drain();
        write_reg(REG_SCAN_POINTS, 16'd4097);
        write_reg(REG_MAX_ANGLE, 16'd8191);
        write_reg(REG_THRESHOLD, 16'd65535);
        rx_mode = 1;
        hold_req = 1;
        random_burst(150);
        drain();
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_THRESHOLD, 16'($urandom));
            write_reg(REG_MAX_ANGLE, 16'($urandom_range(8191, 0)));
            write_reg(REG_SCAN_POINTS, 16'($urandom_range(8191, 0)));
            if ($urandom_range(2, 0) == 0)
                write_reg(2'd3, 16'($urandom));
            rx_mode = $urandom_range(2, 0);
            random_burst(120);
            drain();
        end

        if (board.errors == 0 && board.points_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
